[src/chs_pkg.sv]
// shared constants, types and tables for the compass heading block
package chs_pkg;

  localparam int MAX_WINDOW   = 4096;
  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_ITERS = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
  localparam int ITER_W       = $clog2(CORDIC_ITERS + 1);
  localparam int CW           = 37;   // cordic x/y width
  localparam int DIV_STEPS    = 29;   // dividend bits
  localparam int SQRT_STEPS   = 29;   // root bits
  localparam int NUM_W        = 57;   // variance numerator width
  localparam int STEP_W       = 5;

  localparam logic signed [15:0] RST_X_CENTER  = 16'sd7923;
  localparam logic signed [15:0] RST_Y_CENTER  = 16'sd8044;
  localparam logic signed [15:0] RST_X_GAIN    = 16'sd23264;
  localparam logic signed [15:0] RST_SKEW_GAIN = 16'sd4231;
  localparam logic signed [15:0] RST_Y_GAIN    = 16'sd25794;
  localparam logic [15:0]        RST_OFFSET    = 16'd40115;
  localparam logic [12:0]        RST_WINDOW    = 13'd1000;

  typedef enum logic [2:0] {
    CFG_X_CENTER, CFG_Y_CENTER, CFG_X_GAIN, CFG_SKEW_GAIN,
    CFG_Y_GAIN, CFG_HEADING_OFFSET, CFG_WINDOW_LENGTH
  } chs_cfg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_MUL_XG, ST_MUL_SG, ST_MUL_YG, ST_START, ST_CORDIC,
    ST_SQUARE, ST_ACCUM, ST_MUL_SS, ST_MUL_QL, ST_MUL_QH, ST_NUM,
    ST_DIV_MEAN, ST_SQRT, ST_DIV_SPREAD, ST_EMIT
  } chs_state_t;

  typedef struct packed {
    logic        done;
    logic [31:0] angle;
  } chs_cordic_res_t;

  // arctangent of 2^-i, 2^32 units per turn
  function automatic logic [31:0] atan_unit(input logic [4:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

[src/chs_cordic.sv]
// iterative vectoring cordic, one micro-rotation per cycle
module chs_cordic import chs_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic signed [33:0]  s_in,
  input  logic signed [32:0]  c_in,
  output chs_cordic_res_t     res
);

  logic signed [CW-1:0] x_r, y_r, x_nxt, y_nxt, xs, ys;
  logic [31:0]          z_r, z_nxt;
  logic [ITER_W-1:0]    it_r;
  logic                 busy_r, done_r, zero_r;

  // one rotation step, shifts floor toward minus infinity
  always_comb begin
    xs = x_r >>> it_r;
    ys = y_r >>> it_r;
    if (y_r > 0) begin
      x_nxt = x_r + ys;
      y_nxt = y_r - xs;
      z_nxt = z_r + atan_unit(5'(it_r));
    end else begin
      x_nxt = x_r - ys;
      y_nxt = y_r + xs;
      z_nxt = z_r - atan_unit(5'(it_r));
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      it_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        it_r   <= '0;
      end else if (busy_r) begin
        it_r <= it_r + 1'b1;
        if (it_r == ITER_W'(CORDIC_ITERS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // vector and angle accumulator, left half-plane folded over first
  always_ff @(posedge clk) begin
    if (start) begin
      zero_r <= (s_in == 34'sd0) && (c_in == 33'sd0);
      if (c_in < 0) begin
        x_r <= -CW'(c_in);
        y_r <= -CW'(s_in);
        z_r <= 32'h80000000;
      end else begin
        x_r <= CW'(c_in);
        y_r <= CW'(s_in);
        z_r <= 32'h0;
      end
    end else if (busy_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign res.done  = done_r;
  assign res.angle = zero_r ? 32'h0 : z_r;

endmodule

[src/compass_heading_with_statistics.sv]
// top level: calibrated compass heading with windowed mean and spread
// path from input transaction to result valid: 3 multiplies on the shared multiplier, cordic start,
// 16 cordic rotations and done, square, accumulate, emit
// one sample at a time, next input accepted only once the last result is emitted; a result stall holds emit
// a sample that closes a window adds 3 multiplies and a numerator step, then a 29-step divide,
// 29-step square root and 29-step divide; reset restores defaults, clears sums
module compass_heading_with_statistics import chs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_x_sample,
  input  logic signed [15:0] in_y_sample,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        out_heading,
  output logic [15:0]        out_mean_heading,
  output logic [15:0]        out_heading_spread,
  output logic               out_window_done,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  chs_state_t state_r, state_nxt;

  // configuration
  logic signed [15:0] x_center_r, y_center_r, x_gain_r, skew_gain_r, y_gain_r;
  logic [15:0]        offset_r;
  logic [12:0]        window_r, n_eff;

  // datapath
  logic signed [16:0] dx_r, dy_r;
  logic signed [28:0] mul_a, mul_b;
  logic signed [57:0] prod_r;
  logic signed [33:0] t_r, s_r;
  logic [15:0]        h_r, mean_r;
  logic [12:0]        cnt_r;
  logic [27:0]        sum_r;
  logic [43:0]        sq_r;
  logic               win_r;
  logic [55:0]        b_r;
  logic [34:0]        alo_r;
  logic [NUM_W-1:0]   a_full, num_r;
  logic [12:0]        rem_r;
  logic [13:0]        trial;
  logic [DIV_STEPS-1:0] dq_r;
  logic               div_last, sqrt_last;
  logic [STEP_W-1:0]  step_r;
  logic [NUM_W:0]     v_r, root_r, root_try, root_nxt;
  logic [NUM_W-1:0]   bit_r;
  logic [31:0]        head_tmp;
  logic               out_valid_r, out_done_r;
  logic [15:0]        out_head_r, out_mean_r, out_spread_r;
  logic               emit_go, cordic_start;
  chs_cordic_res_t    cres;

  // effective window length
  always_comb begin
    if (window_r == 13'd0) n_eff = 13'd1;
    else if (window_r > 13'(MAX_WINDOW)) n_eff = 13'(MAX_WINDOW);
    else n_eff = window_r;
  end

  // configuration writes
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_center_r  <= RST_X_CENTER;
      y_center_r  <= RST_Y_CENTER;
      x_gain_r    <= RST_X_GAIN;
      skew_gain_r <= RST_SKEW_GAIN;
      y_gain_r    <= RST_Y_GAIN;
      offset_r    <= RST_OFFSET;
      window_r    <= RST_WINDOW;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_X_CENTER:       x_center_r  <= cfg_data;
        CFG_Y_CENTER:       y_center_r  <= cfg_data;
        CFG_X_GAIN:         x_gain_r    <= cfg_data;
        CFG_SKEW_GAIN:      skew_gain_r <= cfg_data;
        CFG_Y_GAIN:         y_gain_r    <= cfg_data;
        CFG_HEADING_OFFSET: offset_r    <= cfg_data;
        CFG_WINDOW_LENGTH:  window_r    <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_MUL_XG: begin mul_a = 29'(dx_r); mul_b = 29'(x_gain_r); end
      ST_MUL_SG: begin mul_a = 29'(dy_r); mul_b = 29'(skew_gain_r); end
      ST_MUL_YG: begin mul_a = 29'(dy_r); mul_b = 29'(y_gain_r); end
      ST_SQUARE: begin mul_a = {13'd0, h_r}; mul_b = {13'd0, h_r}; end
      ST_MUL_SS: begin mul_a = {1'b0, sum_r}; mul_b = {1'b0, sum_r}; end
      ST_MUL_QL: begin mul_a = {7'd0, sq_r[21:0]}; mul_b = {16'd0, n_eff}; end
      ST_MUL_QH: begin mul_a = {7'd0, sq_r[43:22]}; mul_b = {16'd0, n_eff}; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  chs_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cordic_start),
    .s_in  (s_r),
    .c_in  (prod_r[32:0]),
    .res   (cres)
  );

  // heading after offset, rounded to 65536 units per turn
  assign head_tmp = cres.angle - {offset_r, 16'h0} + 32'h8000;

  // numerator n*Q - S*S, clamped at zero
  assign a_full = NUM_W'(alo_r) + (NUM_W'(prod_r[34:0]) << 22);

  // restoring divide step
  assign trial    = {rem_r, dq_r[DIV_STEPS-1]};
  assign div_last = (step_r == STEP_W'(DIV_STEPS - 1));

  // square root step
  assign root_try  = root_r + (NUM_W+1)'(bit_r);
  assign root_nxt  = (v_r >= root_try) ? ((root_r >> 1) + (NUM_W+1)'(bit_r))
                                       : (root_r >> 1);
  assign sqrt_last = (step_r == STEP_W'(SQRT_STEPS - 1));

  assign emit_go = !out_valid_r || out_ready;

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    cordic_start = 1'b0;
    unique case (state_r)
      ST_IDLE:       if (in_valid) state_nxt = ST_MUL_XG;
      ST_MUL_XG:     state_nxt = ST_MUL_SG;
      ST_MUL_SG:     state_nxt = ST_MUL_YG;
      ST_MUL_YG:     state_nxt = ST_START;
      ST_START: begin
        cordic_start = 1'b1;
        state_nxt    = ST_CORDIC;
      end
      ST_CORDIC:     if (cres.done) state_nxt = ST_SQUARE;
      ST_SQUARE:     state_nxt = ST_ACCUM;
      ST_ACCUM:      state_nxt = (cnt_r + 13'd1 >= n_eff) ? ST_MUL_SS : ST_EMIT;
      ST_MUL_SS:     state_nxt = ST_MUL_QL;
      ST_MUL_QL:     state_nxt = ST_MUL_QH;
      ST_MUL_QH:     state_nxt = ST_NUM;
      ST_NUM:        state_nxt = ST_DIV_MEAN;
      ST_DIV_MEAN:   if (div_last) state_nxt = ST_SQRT;
      ST_SQRT:       if (sqrt_last) state_nxt = ST_DIV_SPREAD;
      ST_DIV_SPREAD: if (div_last) state_nxt = ST_EMIT;
      ST_EMIT:       if (emit_go) state_nxt = ST_IDLE;
      default:       state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  assign in_ready = (state_r == ST_IDLE);

  // window accumulators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      sum_r <= '0;
      sq_r  <= '0;
      win_r <= 1'b0;
    end else if (state_r == ST_ACCUM) begin
      cnt_r <= cnt_r + 13'd1;
      sum_r <= sum_r + 28'(h_r);
      sq_r  <= sq_r + 44'(prod_r[31:0]);
      win_r <= (cnt_r + 13'd1 >= n_eff);
    end else if (state_r == ST_EMIT && emit_go && win_r) begin
      cnt_r <= '0;
      sum_r <= '0;
      sq_r  <= '0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        dx_r <= 17'(in_x_sample) - 17'(x_center_r);
        dy_r <= 17'(in_y_sample) - 17'(y_center_r);
      end
      ST_MUL_SG: t_r <= prod_r[33:0];
      ST_MUL_YG: s_r <= t_r - prod_r[33:0];
      ST_CORDIC: if (cres.done) h_r <= head_tmp[31:16];
      ST_MUL_QL: b_r <= prod_r[55:0];
      ST_MUL_QH: alo_r <= prod_r[34:0];
      ST_NUM: begin
        num_r  <= (a_full > NUM_W'(b_r)) ? (a_full - NUM_W'(b_r)) : '0;
        rem_r  <= '0;
        dq_r   <= DIV_STEPS'(sum_r) + DIV_STEPS'(n_eff >> 1);
        step_r <= '0;
      end
      ST_DIV_MEAN, ST_DIV_SPREAD: begin
        if (trial >= {1'b0, n_eff}) begin
          rem_r <= 13'(trial - {1'b0, n_eff});
          dq_r  <= {dq_r[DIV_STEPS-2:0], 1'b1};
        end else begin
          rem_r <= trial[12:0];
          dq_r  <= {dq_r[DIV_STEPS-2:0], 1'b0};
        end
        step_r <= step_r + 1'b1;
        if (state_r == ST_DIV_MEAN && div_last) begin
          v_r    <= {1'b0, num_r};
          root_r <= '0;
          bit_r  <= NUM_W'(1) << (NUM_W - 1);
          step_r <= '0;
        end
      end
      ST_SQRT: begin
        if (step_r == '0) mean_r <= dq_r[15:0];
        if (v_r >= root_try) v_r <= v_r - root_try;
        root_r <= root_nxt;
        bit_r  <= bit_r >> 2;
        step_r <= step_r + 1'b1;
        if (sqrt_last) begin
          rem_r  <= '0;
          dq_r   <= DIV_STEPS'(root_nxt) + DIV_STEPS'(n_eff >> 1);
          step_r <= '0;
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_EMIT && emit_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_EMIT && emit_go) begin
      out_head_r   <= h_r;
      out_done_r   <= win_r;
      out_mean_r   <= win_r ? mean_r : 16'd0;
      out_spread_r <= win_r ? dq_r[15:0] : 16'd0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_heading        = out_head_r;
  assign out_mean_heading   = out_mean_r;
  assign out_heading_spread = out_spread_r;
  assign out_window_done    = out_done_r;

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 13'(MAX_WINDOW))
    else $error("sample count beyond window limit");

  a_empty_sums: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 13'd0 |-> (sum_r == 28'd0 && sq_r == 44'd0))
    else $error("accumulators not cleared with counter");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready held after accepting a sample");

  a_stats_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_window_done |-> (out_mean_heading == 16'd0 &&
                                       out_heading_spread == 16'd0))
    else $error("window statistics shown outside window end");

endmodule
